[sv/rdb_pkg.sv]
// Shared constants for the random draw bag: field widths, status codes and
// register reset values. No dependencies; every file but rdb_tb_pkg refers to it.
package rdb_pkg;

    // Fixed field widths.
    localparam int CAP_W = 13;
    localparam int VAL_W = 31;
    localparam int RND_W = 32;
    localparam int ST_W  = 2;

    // Default number of store entries.
    localparam int SLOTS_DEFAULT = 4096;

    // Capacity register value after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

endpackage

[sv/rdb_if.sv]
// Channel interfaces of the random draw bag: request, result and capacity write.
// Depends on rdb_pkg for the field widths.

// Request beat: insert or extract.
interface rdb_in_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [rdb_pkg::VAL_W-1:0]  ball_value;
    logic [rdb_pkg::RND_W-1:0]  random_word;

    modport source (output valid, output mode, output ball_value, output random_word,
                    input ready);
    modport sink   (input valid, input mode, input ball_value, input random_word,
                    output ready);
endinterface

// Result beat; the count width follows from the number of slots.
interface rdb_out_if #(
    parameter int CNT_W = 13
);
    logic                       valid;
    logic                       ready;
    logic [rdb_pkg::ST_W-1:0]   status;
    logic [rdb_pkg::VAL_W-1:0]  drawn_value;
    logic [CNT_W-1:0]           count_after;
    logic                       is_empty;

    modport source (output valid, output status, output drawn_value, output count_after,
                    output is_empty, input ready);
    modport sink   (input valid, input status, input drawn_value, input count_after,
                    input is_empty, output ready);
endinterface

// Capacity register write beat.
interface rdb_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [rdb_pkg::CAP_W-1:0]  capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

[sv/random_draw_bag.sv]
// Top level of the random draw bag: control sequencer, count and capacity registers.
// Depends on rdb_pkg, the interfaces in rdb_if, rdb_divider and rdb_store.
//
// A bag of values drawn without replacement. Each request beat on i_in either
// inserts ball_value at the current count, or extracts the entry at
// random_word modulo the count and moves the last entry into its place.
// Every request gives exactly one result beat on o_out with a status, the
// drawn value (zero unless an extract succeeded), the count after the step
// and an empty flag. i_cfg writes the capacity; the effective limit is the
// smaller of capacity and SLOTS. Capacity is to be written only while idle;
// the block itself does not enforce this. An insert, a full insert or an empty
// extract goes from acceptance to the push state, which loads the output
// register, and the sequencer then returns to idle. A successful extract first
// runs the remainder unit (one dividend bit per cycle), then latches the slot,
// does two store reads and one write, and loads the output in the push state.
// One request is worked on at a time. The result sits in an output register,
// so a new request is accepted while the receiver stalls; the sequencer only
// waits if the next result is ready before the previous one was taken.
// Reset empties the bag and sets capacity to 4096; the store is not cleared,
// since only written entries are ever read.
module random_draw_bag #(
    parameter int SLOTS = rdb_pkg::SLOTS_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rdb_in_if.sink        i_in,
    rdb_cfg_if.sink       i_cfg,
    rdb_out_if.source     o_out
);

    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int ADDR_W = $clog2(SLOTS);

    // Sequencer states.
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DIV     = 3'd1;
    localparam logic [2:0] S_RD_SLOT = 3'd2;
    localparam logic [2:0] S_RD_LAST = 3'd3;
    localparam logic [2:0] S_WRITE   = 3'd4;
    localparam logic [2:0] S_PUSH    = 3'd5;

    logic [2:0]                 r_state;
    logic [2:0]                 n_state;
    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           n_count;
    logic [rdb_pkg::CAP_W-1:0]  r_capacity;
    logic [ADDR_W-1:0]          r_slot;
    logic [rdb_pkg::ST_W-1:0]   r_status;
    logic [rdb_pkg::ST_W-1:0]   n_status;
    logic [rdb_pkg::VAL_W-1:0]  r_drawn;
    logic [rdb_pkg::VAL_W-1:0]  n_drawn;

    logic                       r_out_valid;
    logic [rdb_pkg::ST_W-1:0]   r_out_status;
    logic [rdb_pkg::VAL_W-1:0]  r_out_drawn;
    logic [CNT_W-1:0]           r_out_count;
    logic                       r_out_empty;

    logic [CNT_W-1:0]           limit;
    logic                       in_beat;
    logic                       out_free;
    logic                       push;

    logic                       div_start;
    logic                       div_done;
    logic [CNT_W-1:0]           div_rem;

    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [rdb_pkg::VAL_W-1:0]  wr_data;
    logic                       rd_en;
    logic [ADDR_W-1:0]          rd_addr;
    logic [rdb_pkg::VAL_W-1:0]  rd_data;

    // Effective limit: the smaller of capacity and the store size.
    always_comb begin
        if (32'(r_capacity) >= 32'(SLOTS)) begin
            limit = CNT_W'(SLOTS);
        end else begin
            limit = CNT_W'(r_capacity);
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_beat     = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;
    assign push        = (r_state == S_PUSH) && out_free;

    // Sequencer and store port control.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_status  = r_status;
        n_drawn   = r_drawn;
        div_start = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = r_count[ADDR_W-1:0];
        wr_data   = i_in.ball_value;
        rd_en     = 1'b0;
        rd_addr   = r_slot;
        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_status = rdb_pkg::ST_OK;
                    n_drawn  = '0;
                    n_state  = S_PUSH;
                    if (!i_in.mode) begin
                        if (r_count >= limit) begin
                            n_status = rdb_pkg::ST_FULL;
                        end else begin
                            wr_en   = 1'b1;
                            n_count = r_count + CNT_W'(1);
                        end
                    end else if (r_count == '0) begin
                        n_status = rdb_pkg::ST_EMPTY;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_RD_SLOT;
                end
            end
            S_RD_SLOT: begin
                rd_en   = 1'b1;
                n_state = S_RD_LAST;
            end
            S_RD_LAST: begin
                // Drawn value arrives; fetch the last occupied entry.
                n_drawn = rd_data;
                rd_en   = 1'b1;
                rd_addr = ADDR_W'(r_count - CNT_W'(1));
                n_state = S_WRITE;
            end
            S_WRITE: begin
                wr_en   = 1'b1;
                wr_addr = r_slot;
                wr_data = rd_data;
                n_count = r_count - CNT_W'(1);
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_capacity <= rdb_pkg::CAP_RESET;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg.valid && i_cfg.ready) begin
                r_capacity <= i_cfg.capacity;
            end
        end
    end

    // Per-request working registers.
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_drawn  <= n_drawn;
        if (div_done) begin
            r_slot <= div_rem[ADDR_W-1:0];
        end
    end

    // Output register: loaded when a result is ready, cleared when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out_status <= r_status;
            r_out_drawn  <= r_drawn;
            r_out_count  <= r_count;
            r_out_empty  <= (r_count == '0);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.drawn_value = r_out_drawn;
    assign o_out.count_after = r_out_count;
    assign o_out.is_empty    = r_out_empty;

    rdb_divider #(
        .CNT_W (CNT_W)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (i_in.random_word),
        .i_divisor   (r_count),
        .o_done      (div_done),
        .o_remainder (div_rem)
    );

    rdb_store #(
        .SLOTS (SLOTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

[sv/rdb_divider.sv]
// Iterative restoring remainder unit: one dividend bit per cycle.
// Depends on rdb_pkg for the dividend width.
module rdb_divider #(
    parameter int CNT_W = 13
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rdb_pkg::RND_W-1:0]  i_dividend,
    input  logic [CNT_W-1:0]           i_divisor,
    output logic                       o_done,
    output logic [CNT_W-1:0]           o_remainder
);

    localparam int STEP_W = $clog2(rdb_pkg::RND_W);

    logic                       r_busy;
    logic                       r_done;
    logic [STEP_W-1:0]          r_step;
    logic [rdb_pkg::RND_W-1:0]  r_dvd;
    logic [CNT_W-1:0]           r_dsr;
    logic [CNT_W-1:0]           r_rem;
    logic [CNT_W-1:0]           n_rem;
    logic [CNT_W:0]             rem_sh;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        rem_sh = {r_rem, r_dvd[rdb_pkg::RND_W-1]};
        if (rem_sh >= {1'b0, r_dsr}) begin
            n_rem = CNT_W'(rem_sh - {1'b0, r_dsr});
        end else begin
            n_rem = rem_sh[CNT_W-1:0];
        end
    end

    // Control: busy while the dividend bits are shifted in, and done pulses once afterwards.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(rdb_pkg::RND_W - 1);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[rdb_pkg::RND_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

endmodule

[sv/rdb_store.sv]
// Value store of the random draw bag: one write port, one registered read port.
// Depends on rdb_pkg for the value width.
module rdb_store #(
    parameter int SLOTS = rdb_pkg::SLOTS_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(SLOTS)-1:0]   i_wr_addr,
    input  logic [rdb_pkg::VAL_W-1:0]  i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(SLOTS)-1:0]   i_rd_addr,
    output logic [rdb_pkg::VAL_W-1:0]  o_rd_data
);

    logic [rdb_pkg::VAL_W-1:0] r_mem [SLOTS];
    logic [rdb_pkg::VAL_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[dv/rdb_tb_pkg.sv]
// Testbench-side codes for the random draw bag: the request mode encoding.
// No dependencies; shared by the checker and the testbench top.
package rdb_tb_pkg;

    // Request mode carried on the request channel.
    typedef enum logic {
        MODE_INSERT  = 1'b0,
        MODE_EXTRACT = 1'b1
    } req_mode_e;

endpackage

[dv/rdb_checker.sv]
// Checker for the random draw bag: watches the request, capacity and result channels,
// keeps its own copy of the bag and compares every result beat. Uses rdb_pkg, rdb_tb_pkg
// and the channel interfaces of rdb_if.
module rdb_checker
    import rdb_pkg::*;
    import rdb_tb_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT,
    parameter int CNT_W = 13
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rdb_in_if    in_mon,
    rdb_cfg_if   cfg_mon,
    rdb_out_if   out_mon,
    output int   o_mismatches,
    output int   o_pending
);

    // One expected result beat.
    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [VAL_W-1:0] drawn;
        logic [CNT_W-1:0] count;
        logic             empty;
    } draw_result_t;

    draw_result_t     expected_draws[$];
    logic [VAL_W-1:0] bag_vals [SLOTS];
    logic [CNT_W-1:0] bag_count;
    logic [CAP_W-1:0] cap_reg;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    // Applies one request to the shadow bag and returns the result it should give.
    function automatic draw_result_t apply_request(input logic m, input logic [VAL_W-1:0] b,
                                                   input logic [RND_W-1:0] r);
        draw_result_t res;
        int unsigned  lim;
        int unsigned  slot;
        lim        = (int'(cap_reg) < SLOTS) ? int'(cap_reg) : SLOTS;
        res.status = ST_OK;
        res.drawn  = '0;
        if (m == MODE_INSERT) begin
            if (bag_count >= lim) begin
                res.status = ST_FULL;
            end else begin
                bag_vals[bag_count] = b;
                bag_count           = bag_count + 1'b1;
            end
        end else if (bag_count == 0) begin
            res.status = ST_EMPTY;
        end else begin
            // Swap-remove: the last held value fills the drawn slot.
            slot           = r % bag_count;
            res.drawn      = bag_vals[slot];
            bag_count      = bag_count - 1'b1;
            bag_vals[slot] = bag_vals[bag_count];
        end
        res.count = bag_count;
        res.empty = (bag_count == 0);
        return res;
    endfunction

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_mismatches++;
    endtask

    // Result beats are matched first, since a beat leaving now belongs to an older request.
    always @(posedge i_clk) begin
        draw_result_t want;
        if (!i_rst_n) begin
            bag_count = '0;
            cap_reg   = CAP_RESET;
            expected_draws.delete();
        end else begin
            if (out_mon.valid && out_mon.ready) begin
                if (expected_draws.size() == 0) begin
                    report_mismatch($sformatf("result beat with none expected (status %0d)",
                                              out_mon.status));
                end else begin
                    want = expected_draws.pop_front();
                    if (out_mon.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  out_mon.status, want.status));
                    if (out_mon.drawn_value !== want.drawn)
                        report_mismatch($sformatf("drawn_value %0h, expected %0h",
                                                  out_mon.drawn_value, want.drawn));
                    if (out_mon.count_after !== want.count)
                        report_mismatch($sformatf("count_after %0d, expected %0d",
                                                  out_mon.count_after, want.count));
                    if (out_mon.is_empty !== want.empty)
                        report_mismatch($sformatf("is_empty %0b, expected %0b",
                                                  out_mon.is_empty, want.empty));
                end
            end
            if (cfg_mon.valid && cfg_mon.ready) begin
                cap_reg = cfg_mon.capacity;
            end
            if (in_mon.valid && in_mon.ready) begin
                expected_draws.push_back(apply_request(in_mon.mode, in_mon.ball_value,
                                                       in_mon.random_word));
            end
        end
        o_pending = expected_draws.size();
    end

endmodule

[dv/random_draw_bag_tb.sv]
// Testbench top for the random draw bag: clock, reset, request and capacity stimulus,
// result back-pressure and the verdict. Uses rdb_pkg, rdb_tb_pkg, rdb_if and rdb_checker.
module random_draw_bag_tb;
    import rdb_pkg::*;
    import rdb_tb_pkg::*;

    localparam int SLOTS      = SLOTS_DEFAULT;
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int PHASES     = 8;
    localparam int PHASE_REQS = 72;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_MOSTLY,
        RX_BURSTY
    } rx_pattern_e;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   chk_mismatches;
    int   chk_pending;

    rdb_in_if                    req_ch ();
    rdb_cfg_if                   cap_ch ();
    rdb_out_if #(.CNT_W(CNT_W))  res_ch ();

    random_draw_bag #(.SLOTS(SLOTS)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .i_cfg   (cap_ch),
        .o_out   (res_ch)
    );

    rdb_checker #(.SLOTS(SLOTS), .CNT_W(CNT_W)) i_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_mon       (req_ch),
        .cfg_mon      (cap_ch),
        .out_mon      (res_ch),
        .o_mismatches (chk_mismatches),
        .o_pending    (chk_pending)
    );

    // Clock with a period of 10.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Known values on every block input from time zero.
    initial begin
        req_ch.valid       = 1'b0;
        req_ch.mode        = MODE_INSERT;
        req_ch.ball_value  = '0;
        req_ch.random_word = '0;
        cap_ch.valid       = 1'b0;
        cap_ch.capacity    = '0;
        res_ch.ready       = 1'b0;
    end

    // Receiver back-pressure: a pattern that is picked anew at random whenever its run ends.
    rx_pattern_e rx_pat  = RX_OPEN;
    int          rx_left = 0;

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_pat  = rx_pattern_e'($urandom_range(0, 3));
            rx_left = $urandom_range(8, 120);
        end
        rx_left--;
        case (rx_pat)
            RX_OPEN:   res_ch.ready <= 1'b1;
            RX_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
            RX_MOSTLY: res_ch.ready <= ($urandom_range(0, 7) != 0);
            default:   res_ch.ready <= ((rx_left % 32) >= 20);
        endcase
    end

    // Presents one request beat; called and returns at a falling edge.
    task automatic send_req(input req_mode_e m, input logic [VAL_W-1:0] b,
                            input logic [RND_W-1:0] r);
        req_ch.valid       <= 1'b1;
        req_ch.mode        <= m;
        req_ch.ball_value  <= b;
        req_ch.random_word <= r;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    // Sender gap: drops the request valid and waits; n sets the gap and is at least one.
    task automatic idle_cycles(input int n);
        req_ch.valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Holds the sender off until every expected result has been taken.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do @(negedge i_clk); while (chk_pending != 0);
    endtask

    // Writes the capacity register with the bag idle.
    task automatic write_cap(input logic [CAP_W-1:0] v);
        drain_results();
        cap_ch.valid    <= 1'b1;
        cap_ch.capacity <= v;
        do @(posedge i_clk); while (cap_ch.ready !== 1'b1);
        @(negedge i_clk);
        cap_ch.valid <= 1'b0;
    endtask

    // One random request; the random word is often near the ends of its range.
    task automatic send_random(input int ins_pct);
        req_mode_e        m;
        logic [VAL_W-1:0] b;
        logic [RND_W-1:0] r;
        m = ($urandom_range(0, 99) < ins_pct) ? MODE_INSERT : MODE_EXTRACT;
        b = VAL_W'($urandom);
        case ($urandom_range(0, 3))
            0, 1:    r = $urandom;
            2:       r = $urandom_range(0, 15);
            default: r = 32'hFFFF_FFFF - $urandom_range(0, 15);
        endcase
        send_req(m, b, r);
    endtask

    // Capacity and insert share for each random phase.
    logic [CAP_W-1:0] phase_caps [PHASES] = '{13'd2, 13'd7, 13'd0, 13'd1,
                                              13'd8191, 13'd4096, 13'd33, 13'd300};
    int               phase_ins  [PHASES] = '{55, 50, 60, 40, 70, 65, 50, 80};

    // Stimulus and verdict.
    initial begin
        int burst;
        int gap;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty extract, value extremes and slot selection at the default capacity.
        send_req(MODE_EXTRACT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_req(MODE_INSERT,  31'h7FFF_FFFF, 32'h0);
        send_req(MODE_INSERT,  31'h0,         32'hFFFF_FFFF);
        send_req(MODE_INSERT,  31'h2AAA_AAAA, 32'h5555_5555);
        send_req(MODE_INSERT,  31'h5555_5555, 32'hAAAA_AAAA);
        send_req(MODE_EXTRACT, 31'h0,         32'h0);
        send_req(MODE_EXTRACT, 31'h0,         32'hFFFF_FFFF);
        send_req(MODE_EXTRACT, 31'h7FFF_FFFF, 32'h1);
        send_req(MODE_EXTRACT, 31'h0,         32'h8000_0000);
        send_req(MODE_EXTRACT, 31'h0,         32'h0);

        // Smallest normal capacity, filled past its limit.
        write_cap(13'd2);
        send_req(MODE_INSERT, 31'h1234_5678, 32'h0);
        send_req(MODE_INSERT, 31'h0765_4321, 32'h0);
        send_req(MODE_INSERT, 31'h7FFF_FFFE, 32'h0);

        // Capacity of one, lowered below the held count.
        write_cap(13'd1);
        send_req(MODE_INSERT,  31'h1,  32'h0);
        send_req(MODE_EXTRACT, 31'h0,  32'h3);
        send_req(MODE_INSERT,  31'h2,  32'h0);
        send_req(MODE_EXTRACT, 31'h0,  32'h7);
        send_req(MODE_INSERT,  31'h3,  32'h0);
        send_req(MODE_INSERT,  31'h4,  32'h0);

        // Capacity of zero: every insert is refused.
        write_cap(13'd0);
        send_req(MODE_INSERT,  31'h5, 32'h0);
        send_req(MODE_EXTRACT, 31'h0, 32'h0);
        send_req(MODE_INSERT,  31'h6, 32'h0);

        // Capacity above the store size.
        write_cap(13'd8191);
        send_req(MODE_INSERT,  31'h7, 32'h0);
        send_req(MODE_EXTRACT, 31'h0, 32'h2);

        // Random phases with bursts, gaps and an occasional full drain.
        for (int p = 0; p < PHASES; p++) begin
            write_cap(phase_caps[p]);
            burst = $urandom_range(1, 12);
            for (int k = 0; k < PHASE_REQS; k++) begin
                send_random(phase_ins[p]);
                burst--;
                if (burst == 0) begin
                    if ($urandom_range(0, 39) == 0) begin
                        drain_results();
                    end else begin
                        gap = $urandom_range(0, 6);
                        if (gap > 0)
                            idle_cycles(gap);
                    end
                    burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                        : $urandom_range(1, 12);
                end
            end
        end

        drain_results();
        repeat (40) @(negedge i_clk);
        if (chk_mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
